>>> hdl/bcgs_pkg.sv
// Shared types, widths and constants of the B-spline charge grid spreader.
`timescale 1ns / 1ps
`default_nettype none
package bcgs_pkg;

	// fixed-point widths
	localparam int W_W   = 17;  // Q16 spline weight, up to 1.0
	localparam int X_W   = 20;  // f + j, or k - f - j, in Q16
	localparam int NUM_W = 38;  // recursion numerator
	localparam int T_W   = 22;  // numerator plus half the divisor, shifted down to Q16
	localparam int Q_W   = 23;  // quotient estimate
	localparam int ACC_W = 40;  // grid accumulator, Q24

	localparam logic [W_W-1:0] ONE_Q16 = 17'h10000;

	// item kinds
	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_SPREAD = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	// floor(2^22 / d) for the small recursion divisors
	function automatic logic [Q_W-1:0] recip(input logic [2:0] d);
		logic [Q_W-1:0] m;
		case (d)
			3'd1: m = 23'd4194304;
			3'd2: m = 23'd2097152;
			3'd3: m = 23'd1398101;
			3'd4: m = 23'd1048576;
			3'd5: m = 23'd838860;
			3'd6: m = 23'd699050;
			3'd7: m = 23'd599186;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

>>> hdl/bcgs_spline.sv
// Sequential unit that forms the per-axis cardinal B-spline weights.
`timescale 1ns / 1ps
`default_nettype none
module bcgs_spline #(
	parameter int SPLINE_ORDER = 7
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        start,
	input  wire logic [2:0][15:0]                            frac,
	output logic                                             done,
	output logic [2:0][SPLINE_ORDER-1:0][bcgs_pkg::W_W-1:0]  weights
);
	import bcgs_pkg::*;

	localparam int KW = $clog2(SPLINE_ORDER + 1);
	localparam int JW = (SPLINE_ORDER > 2) ? $clog2(SPLINE_ORDER) : 1;

	localparam logic [2:0] W_IDLE = 3'd0;
	localparam logic [2:0] W_MA   = 3'd1;
	localparam logic [2:0] W_MB   = 3'd2;
	localparam logic [2:0] W_Q    = 3'd3;
	localparam logic [2:0] W_FIX  = 3'd4;

	logic [2:0]                         state_q;
	logic [1:0]                         ax_q;
	logic [KW-1:0]                      k_q;
	logic [JW-1:0]                      j_q;
	logic [NUM_W-1:0]                   p1_q;
	logic [T_W-1:0]                     t_q;
	logic [Q_W-1:0]                     q0_q;
	logic                               done_q;
	logic [2:0][SPLINE_ORDER-1:0][W_W-1:0] w_q;

	logic [15:0]      f_sel;
	logic [2:0]       d;
	logic [X_W-1:0]   x;
	logic [X_W-1:0]   rest;
	logic [W_W-1:0]   w_hi;
	logic [W_W-1:0]   w_lo;
	logic [NUM_W-1:0] num;
	logic [NUM_W-1:0] num_rnd;
	logic [Q_W+2:0]   qd;
	logic [Q_W+2:0]   rem;
	logic [Q_W-1:0]   q_fix;

	// operands of one recursion term
	always_comb begin
		f_sel   = frac[ax_q];
		d       = 3'(k_q - KW'(1));
		x       = X_W'({j_q, f_sel});
		rest    = X_W'({k_q, 16'h0}) - x;
		w_hi    = w_q[ax_q][j_q];
		w_lo    = (j_q == '0) ? '0 : w_q[ax_q][JW'(j_q - JW'(1))];
		num     = p1_q + NUM_W'(rest * w_lo);
		num_rnd = num + NUM_W'({d, 15'h0});
		qd      = (Q_W+3)'(q0_q * d);
		rem     = (Q_W+3)'(t_q) - qd;
		q_fix   = (rem >= (Q_W+3)'(d)) ? Q_W'(q0_q + Q_W'(1)) : q0_q;
	end

	// recursion sequencer: axis, order k, and j from k-1 down to 0 in place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			ax_q    <= '0;
			k_q     <= '0;
			j_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				W_IDLE: begin
					if (start) begin
						ax_q <= '0;
						k_q  <= KW'(3);
						j_q  <= JW'(2);
						if (SPLINE_ORDER > 2) state_q <= W_MA;
						else done_q <= 1'b1;
					end
				end
				W_MA:  state_q <= W_MB;
				W_MB:  state_q <= W_Q;
				W_Q:   state_q <= W_FIX;
				W_FIX: begin
					state_q <= W_MA;
					if (j_q != '0) begin
						j_q <= JW'(j_q - JW'(1));
					end else if (k_q != KW'(SPLINE_ORDER)) begin
						j_q <= JW'(k_q);
						k_q <= KW'(k_q + KW'(1));
					end else if (ax_q != 2'd2) begin
						ax_q <= ax_q + 2'd1;
						k_q  <= KW'(3);
						j_q  <= JW'(2);
					end else begin
						state_q <= W_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == W_IDLE && start) begin
			for (int a = 0; a < 3; a++) begin
				for (int j = 2; j < SPLINE_ORDER; j++) w_q[a][j] <= '0;
				w_q[a][0] <= {1'b0, frac[a]};
				w_q[a][1] <= ONE_Q16 - {1'b0, frac[a]};
			end
		end
		if (state_q == W_MA) p1_q <= NUM_W'(x * w_hi);
		if (state_q == W_MB) t_q <= num_rnd[16 +: T_W];
		if (state_q == W_Q) q0_q <= Q_W'(((T_W+Q_W)'(t_q) * (T_W+Q_W)'(recip(d))) >> 22);
		if (state_q == W_FIX) w_q[ax_q][j_q] <= W_W'(q_fix);
	end

	assign done    = done_q;
	assign weights = w_q;

endmodule
`default_nettype wire

>>> hdl/bspline_charge_grid_spreader.sv
// Top level: charge grid memory, item sequencer, spread pipeline, register port.
`timescale 1ns / 1ps
`default_nettype none
// Items are taken on start while busy is low; a read returns its word for one cycle on done,
// and the receiver cannot stall it. A clear sweeps every grid word, one per cycle. A read
// wraps its indices by repeated subtraction, one subtract per cycle, before its memory read.
// A spread first runs the weight recursion, which steps each term through the MA, MB, Q and
// FIX states and divides by multiplying with a reciprocal; then the grid update does one
// read-modify-write per cycle, with the read and the write on separate memory ports.
module bspline_charge_grid_spreader #(
	parameter int GRID_MAX     = 64,
	parameter int SPLINE_ORDER = 7
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [21:0] pos_x,
	input  wire logic [21:0] pos_y,
	input  wire logic [21:0] pos_z,
	input  wire logic signed [7:0] charge,
	input  wire logic [5:0]  read_x,
	input  wire logic [5:0]  read_y,
	input  wire logic [5:0]  read_z,
	output logic             done,
	output logic signed [39:0] grid_value,
	output logic             saturated
);
	import bcgs_pkg::*;

	localparam int GB    = $clog2(GRID_MAX);
	localparam int SW    = $clog2(GRID_MAX + 1);
	localparam int CW    = (SW > 6) ? SW : 6;
	localparam int AW    = 3 * GB;
	localparam int DEPTH = 1 << AW;
	localparam int JW    = (SPLINE_ORDER > 1) ? $clog2(SPLINE_ORDER) : 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLR   = 3'd1;
	localparam logic [2:0] S_RMOD  = 3'd2;
	localparam logic [2:0] S_RDAT  = 3'd3;
	localparam logic [2:0] S_SMOD  = 3'd4;
	localparam logic [2:0] S_WGT   = 3'd5;
	localparam logic [2:0] S_SPRD  = 3'd6;
	localparam logic [2:0] S_DRAIN = 3'd7;

	localparam logic [1:0] REG_GPX = 2'd0;
	localparam logic [1:0] REG_GPY = 2'd1;
	localparam logic [1:0] REG_GPZ = 2'd2;

	// configuration registers
	logic [6:0] gpx_q, gpy_q, gpz_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpx_q <= 7'd60;
			gpy_q <= 7'd60;
			gpz_q <= 7'd60;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_GPX: gpx_q <= pwdata[6:0];
				REG_GPY: gpy_q <= pwdata[6:0];
				REG_GPZ: gpz_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_GPX: prdata = {25'h0, gpx_q};
			REG_GPY: prdata = {25'h0, gpy_q};
			REG_GPZ: prdata = {25'h0, gpz_q};
			default: prdata = '0;
		endcase
	end

	// effective grid sizes, clamped to [8, GRID_MAX]
	function automatic logic [SW-1:0] eff_size(input logic [6:0] r);
		logic [SW-1:0] s;
		if (r < 7'd8) s = SW'(8);
		else if ({1'b0, r} > 8'(GRID_MAX)) s = SW'(GRID_MAX);
		else s = SW'(r);
		return s;
	endfunction

	function automatic logic [GB-1:0] dec_wrap(input logic [GB-1:0] g, input logic [SW-1:0] s);
		logic [GB-1:0] r;
		if (g == '0) r = GB'(s - SW'(1));
		else r = g - GB'(1);
		return r;
	endfunction

	logic [2:0][SW-1:0] size;
	assign size[0] = eff_size(gpx_q);
	assign size[1] = eff_size(gpy_q);
	assign size[2] = eff_size(gpz_q);

	// sequencer state
	logic [2:0]             state_q;
	logic [2:0][CW-1:0]     g_q;        // wrapped indices / spread base
	logic [2:0][15:0]       frac_q;
	logic [7:0]             mag_q;
	logic                   neg_q;
	logic                   ovf_q;
	logic [AW-1:0]          clr_q;
	logic [JW-1:0]          jx_q, jy_q, jz_q;
	logic [GB-1:0]          gx_q, gy_q, gz_q;
	logic                   wgt_start_q;
	logic                   wgt_done;
	logic [2:0][SPLINE_ORDER-1:0][W_W-1:0] wgt;
	logic [2:0]             in_range;
	logic                   mod_done;
	logic                   accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		for (int a = 0; a < 3; a++) in_range[a] = (g_q[a] < CW'(size[a]));
	end
	assign mod_done = &in_range;

	// spread pipeline registers
	logic                   v_s1, v_s2, v_s3;
	logic [2*W_W-1:0]       wxy_s1;
	logic [W_W-1:0]         wz_s1, wz_s2;
	logic [AW-1:0]          addr_s1, addr_s2, addr_s3;
	logic [2*W_W+7:0]       mw_s2;
	logic [ACC_W-1:0]       add_s3;
	logic [ACC_W-1:0]       rdata_q;

	logic [3*W_W+7:0]       prod;
	logic [34:0]            contrib;
	logic [ACC_W:0]         sum;
	logic                   sat_hit;
	logic [ACC_W-1:0]       sat_val;

	// contribution rounding, half away from zero on the magnitude
	always_comb begin
		prod    = (3*W_W+8)'(mw_s2) * (3*W_W+8)'(wz_s2);
		contrib = 35'((prod + (3*W_W+8)'(24'h800000)) >> 24);
	end

	// saturating accumulate
	always_comb begin
		sum     = {rdata_q[ACC_W-1], rdata_q} + {add_s3[ACC_W-1], add_s3};
		sat_hit = (sum[ACC_W] != sum[ACC_W-1]);
		if (!sat_hit) sat_val = sum[ACC_W-1:0];
		else if (sum[ACC_W]) sat_val = {1'b1, (ACC_W-1)'(0)};
		else sat_val = {1'b0, {(ACC_W-1){1'b1}}};
	end

	// memory port control
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_wa, mem_ra;
	logic [ACC_W-1:0]  mem_wd;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_s3;
		mem_wd = sat_val;
		if (state_q == S_CLR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (v_s3) begin
			mem_we = 1'b1;
		end
		mem_re = v_s2 || (state_q == S_RMOD && mod_done);
		mem_ra = v_s2 ? addr_s2 : {g_q[0][GB-1:0], g_q[1][GB-1:0], g_q[2][GB-1:0]};
	end

	// charge grid memory
	logic [ACC_W-1:0] grid_mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (mem_we) grid_mem[mem_wa] <= mem_wd;
		if (mem_re) rdata_q <= grid_mem[mem_ra];
	end

	// weight unit
	bcgs_spline #(
		.SPLINE_ORDER(SPLINE_ORDER)
	) u_spline (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (wgt_start_q),
		.frac    (frac_q),
		.done    (wgt_done),
		.weights (wgt)
	);

	// item sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ovf_q       <= 1'b0;
			clr_q       <= '0;
			wgt_start_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			jx_q        <= '0;
			jy_q        <= '0;
			jz_q        <= '0;
		end else begin
			wgt_start_q <= 1'b0;
			v_s1 <= (state_q == S_SPRD);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3 && sat_hit) ovf_q <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (kind)
							KIND_CLEAR: begin
								state_q <= S_CLR;
								clr_q   <= '0;
								ovf_q   <= 1'b0;
							end
							KIND_SPREAD: state_q <= S_SMOD;
							KIND_READ:   state_q <= S_RMOD;
							default: ;
						endcase
					end
				end
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == {AW{1'b1}}) state_q <= S_IDLE;
				end
				S_RMOD: if (mod_done) state_q <= S_RDAT;
				S_RDAT: state_q <= S_IDLE;
				S_SMOD: begin
					if (mod_done) begin
						state_q     <= S_WGT;
						wgt_start_q <= 1'b1;
					end
				end
				S_WGT: begin
					if (wgt_done) begin
						state_q <= S_SPRD;
						jx_q    <= '0;
						jy_q    <= '0;
						jz_q    <= '0;
					end
				end
				S_SPRD: begin
					if (jz_q != JW'(SPLINE_ORDER - 1)) begin
						jz_q <= jz_q + JW'(1);
					end else begin
						jz_q <= '0;
						if (jy_q != JW'(SPLINE_ORDER - 1)) begin
							jy_q <= jy_q + JW'(1);
						end else begin
							jy_q <= '0;
							if (jx_q != JW'(SPLINE_ORDER - 1)) jx_q <= jx_q + JW'(1);
							else state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: if (!v_s1 && !v_s2 && !v_s3) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item operands, index wrap by repeated subtraction, grid walk
	always_ff @(posedge clk) begin
		if (accept) begin
			if (kind == KIND_READ) begin
				g_q[0] <= CW'(read_x);
				g_q[1] <= CW'(read_y);
				g_q[2] <= CW'(read_z);
			end else begin
				g_q[0] <= CW'(pos_x[21:16]);
				g_q[1] <= CW'(pos_y[21:16]);
				g_q[2] <= CW'(pos_z[21:16]);
			end
			frac_q[0] <= pos_x[15:0];
			frac_q[1] <= pos_y[15:0];
			frac_q[2] <= pos_z[15:0];
			mag_q     <= charge[7] ? 8'(-charge) : 8'(charge);
			neg_q     <= charge[7];
		end else if (state_q == S_RMOD || state_q == S_SMOD) begin
			for (int a = 0; a < 3; a++) begin
				if (!in_range[a]) g_q[a] <= g_q[a] - CW'(size[a]);
			end
		end
		if (state_q == S_WGT) begin
			gx_q <= g_q[0][GB-1:0];
			gy_q <= g_q[1][GB-1:0];
			gz_q <= g_q[2][GB-1:0];
		end else if (state_q == S_SPRD) begin
			if (jz_q != JW'(SPLINE_ORDER - 1)) begin
				gz_q <= dec_wrap(gz_q, size[2]);
			end else begin
				gz_q <= g_q[2][GB-1:0];
				if (jy_q != JW'(SPLINE_ORDER - 1)) begin
					gy_q <= dec_wrap(gy_q, size[1]);
				end else begin
					gy_q <= g_q[1][GB-1:0];
					gx_q <= dec_wrap(gx_q, size[0]);
				end
			end
		end
	end

	// contribution pipeline
	always_ff @(posedge clk) begin
		wxy_s1  <= (2*W_W)'(wgt[0][jx_q] * wgt[1][jy_q]);
		wz_s1   <= wgt[2][jz_q];
		addr_s1 <= {gx_q, gy_q, gz_q};
		mw_s2   <= (2*W_W+8)'(wxy_s1 * mag_q);
		wz_s2   <= wz_s1;
		addr_s2 <= addr_s1;
		add_s3  <= neg_q ? ACC_W'(-{5'h0, contrib}) : ACC_W'({5'h0, contrib});
		addr_s3 <= addr_s2;
	end

	// read result word
	assign done       = (state_q == S_RDAT);
	assign grid_value = rdata_q;
	assign saturated  = ovf_q;

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Testbench for the B-spline charge grid spreader: directed and random items against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import bcgs_pkg::*;

	localparam int ORDER     = 7;
	localparam int GMAX      = 64;
	localparam int ONE       = 65536;
	localparam longint CYCLE_LIMIT = 8000000;
	localparam logic [3:0] ADDR_GX = 4'd0;
	localparam logic [3:0] ADDR_GY = 4'd4;
	localparam logic [3:0] ADDR_GZ = 4'd8;
	localparam logic [1:0] KIND_NONE = 2'd3;

	typedef struct packed {
		logic signed [39:0] grid_value;
		logic               saturated;
	} grid_word_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic start, busy, done, saturated;
	logic [1:0] kind;
	logic [21:0] pos_x, pos_y, pos_z;
	logic signed [7:0] charge;
	logic [5:0] read_x, read_y, read_z;
	logic signed [39:0] grid_value;

	bspline_charge_grid_spreader dut (.*);

	// predictor state
	longint grid_cells[int];
	bit overflow_flag;
	int unsigned size_reg[3];
	grid_word_t reads_pending[$];
	int fail_count;
	longint cycle_count = 0;
	bit no_gaps;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("bspline_charge_grid_spreader test failed");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		grid_word_t want;
		if (arst_n && done) begin
			if (reads_pending.size() == 0) begin
				$error("unexpected word: grid_value %0d saturated %0d", grid_value, saturated);
				fail_count++;
			end else begin
				want = reads_pending.pop_front();
				if (grid_value !== want.grid_value) begin
					$error("grid_value expected %0d actual %0d", want.grid_value, grid_value);
					fail_count++;
				end
				if (saturated !== want.saturated) begin
					$error("saturated expected %0d actual %0d", want.saturated, saturated);
					fail_count++;
				end
			end
		end
	end

	function automatic int unsigned eff_size(int unsigned r);
		if (r < 8) return 8;
		if (r > GMAX) return GMAX;
		return r;
	endfunction

	// cardinal B-spline weights in Q16 by the order recursion
	function automatic void bspline_weights(input longint unsigned f,
			output longint unsigned w[ORDER]);
		longint unsigned prev[ORDER+1];
		longint unsigned dv, x, rest, lo, num;
		for (int j = 0; j < ORDER; j++) w[j] = 0;
		for (int j = 0; j <= ORDER; j++) prev[j] = 0;
		w[0] = f;
		w[1] = ONE - f;
		for (int k = 3; k <= ORDER; k++) begin
			dv = longint'(k - 1) << 16;
			for (int j = 0; j < k - 1; j++) prev[j] = w[j];
			prev[k-1] = 0;
			for (int j = 0; j < k; j++) begin
				x = f + longint'(j) * ONE;
				rest = longint'(k) * ONE - x;
				lo = (j > 0) ? prev[j-1] : 0;
				num = x * prev[j] + rest * lo;
				w[j] = (num + (dv >> 1)) / dv;
			end
		end
	endfunction

	function automatic void add_cell(int idx, longint add);
		longint v;
		v = (grid_cells.exists(idx) ? grid_cells[idx] : 0) + add;
		if (v > 64'sd549755813887) begin v = 64'sd549755813887; overflow_flag = 1; end
		if (v < -64'sd549755813888) begin v = -64'sd549755813888; overflow_flag = 1; end
		grid_cells[idx] = v;
	endfunction

	function automatic void predict_spread(logic [21:0] p[3], logic signed [7:0] q);
		int unsigned sz[3], base[3];
		longint unsigned w[3][ORDER];
		longint unsigned mag, wxy, m;
		int unsigned gx, gy, gz;
		bit neg;
		neg = q < 0;
		mag = neg ? longint'(-int'(q)) : longint'(q);
		for (int a = 0; a < 3; a++) begin
			sz[a] = eff_size(size_reg[a]);
			base[a] = (p[a] >> 16) % sz[a];
			bspline_weights(p[a][15:0], w[a]);
		end
		for (int jx = 0; jx < ORDER; jx++) begin
			gx = (base[0] + sz[0] * 8 - jx) % sz[0];
			for (int jy = 0; jy < ORDER; jy++) begin
				gy = (base[1] + sz[1] * 8 - jy) % sz[1];
				wxy = w[0][jx] * w[1][jy];
				for (int jz = 0; jz < ORDER; jz++) begin
					gz = (base[2] + sz[2] * 8 - jz) % sz[2];
					m = (mag * wxy * w[2][jz] + (64'd1 << 23)) >> 24;
					add_cell((gx * GMAX + gy) * GMAX + gz, neg ? -longint'(m) : longint'(m));
				end
			end
		end
	endfunction

	function automatic void predict_item(logic [1:0] k, logic [21:0] p[3],
			logic signed [7:0] q, logic [5:0] r[3]);
		grid_word_t g;
		int idx;
		longint v;
		case (k)
			KIND_CLEAR: begin
				grid_cells.delete();
				overflow_flag = 0;
			end
			KIND_SPREAD: predict_spread(p, q);
			KIND_READ: begin
				idx = ((r[0] % eff_size(size_reg[0])) * GMAX + (r[1] % eff_size(size_reg[1])))
					* GMAX + (r[2] % eff_size(size_reg[2]));
				v = grid_cells.exists(idx) ? grid_cells[idx] : 0;
				g.grid_value = v[39:0];
				g.saturated = overflow_flag;
				reads_pending.push_back(g);
			end
			default: ;
		endcase
	endfunction

	// send one item; after the accepting edge start is left high, or dropped for a random gap
	task automatic send_item(logic [1:0] k, logic [21:0] px, logic [21:0] py, logic [21:0] pz,
			logic signed [7:0] q, logic [5:0] rx, logic [5:0] ry, logic [5:0] rz);
		logic [21:0] p[3];
		logic [5:0] r[3];
		p = '{px, py, pz};
		r = '{rx, ry, rz};
		start <= 1'b1;
		kind <= k; pos_x <= px; pos_y <= py; pos_z <= pz; charge <= q;
		read_x <= rx; read_y <= ry; read_z <= rz;
		do @(posedge clk); while (busy);
		predict_item(k, p, q, r);
		// random gap after the word
		if (!no_gaps && $urandom_range(0, 99) < 34) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_read(int rx, int ry, int rz);
		send_item(KIND_READ, 0, 0, 0, 0, rx, ry, rz);
	endtask

	task automatic send_spread(logic [21:0] px, logic [21:0] py, logic [21:0] pz,
			logic signed [7:0] q);
		send_item(KIND_SPREAD, px, py, pz, q, 0, 0, 0);
	endtask

	// let the block go idle: all reads back, then busy low, then a margin
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (reads_pending.size() != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic reg_write(logic [3:0] addr, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		size_reg[addr >> 2] = val[6:0];
	endtask

	task automatic set_grid(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz);
		drain();
		reg_write(ADDR_GX, gx);
		reg_write(ADDR_GY, gy);
		reg_write(ADDR_GZ, gz);
		@(posedge clk);
	endtask

	function automatic logic [21:0] rand_pos(int axis);
		if ($urandom_range(0, 99) < 70)
			return {6'($urandom_range(0, eff_size(size_reg[axis]) - 1)), 16'($urandom)};
		return 22'($urandom);
	endfunction

	// directed corners on the default grid size
	task automatic test_directed();
		send_item(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		send_read(0, 0, 0);
		send_read(63, 63, 63);
		send_spread(22'h0, 22'h0, 22'h0, 8'sd127);
		send_read(0, 0, 0);
		send_read(59, 59, 59);
		send_spread(22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, -8'sd128);
		send_read(63, 63, 63);
		send_read(3, 3, 3);
		send_spread(22'h0FFFF, 22'h08000, 22'h3B0001, 8'sd0);
		send_spread(22'h05_8000, 22'h02_0001, 22'h3A_FFFF, -8'sd1);
		send_read(5, 2, 58);
		send_read(2, 0, 55);
		send_item(KIND_NONE, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 8'sd127, 63, 63, 63);
		send_read(63, 0, 63);
		send_spread(22'h3C_0000, 22'h00_0001, 22'h3B_FFFF, 8'sd1);
		send_read(0, 0, 59);
	endtask

	task automatic test_random(int n, bit with_clear);
		int roll;
		int clear_at;
		clear_at = with_clear ? $urandom_range(n / 4, n / 2) : -1;
		for (int i = 0; i < n; i++) begin
			no_gaps = (i >= n / 3) && (i < n / 3 + 60);
			roll = $urandom_range(0, 99);
			if (i == clear_at)
				send_item(KIND_CLEAR, 22'($urandom), 22'($urandom), 22'($urandom),
					8'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
			else if (roll < 45)
				send_spread(rand_pos(0), rand_pos(1), rand_pos(2), 8'($urandom));
			else if (roll < 95)
				send_item(KIND_READ, 22'($urandom), 22'($urandom), 22'($urandom),
					8'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
			else
				send_item(KIND_NONE, 22'($urandom), 22'($urandom), 22'($urandom),
					8'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
		end
		no_gaps = 0;
	endtask

	// sender holds off until every read has returned, then resumes
	task automatic test_pause();
		send_read($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
		drain();
		send_read(1, 2, 3);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		start = 0; kind = '0; pos_x = '0; pos_y = '0; pos_z = '0; charge = '0;
		read_x = '0; read_y = '0; read_z = '0;
		size_reg = '{60, 60, 60};
		overflow_flag = 0;
		fail_count = 0;
		no_gaps = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pause();
		set_grid(8, 64, 33);
		test_random(480, 0);
		set_grid(127, 0, 60);
		test_random(480, 1);
		set_grid(5, 17, 64);
		test_random(480, 0);

		drain();
		if (fail_count == 0)
			$display("bspline_charge_grid_spreader test passed");
		else
			$display("bspline_charge_grid_spreader test failed");
		$finish;
	end

endmodule
`default_nettype wire
